/* sv/tcsd_pkg.sv */
// ----------------------------------------------------------------------------
// tcsd_pkg
// Shared types and constants of the tagged chunk stream deframer.
// ----------------------------------------------------------------------------
package tcsd_pkg;

    localparam int unsigned HDR_BYTES       = 8;
    localparam int unsigned HDR_MIN_PAYLOAD = 24;

    localparam logic [31:0] TAG_HDR = 32'h4D56_6864;
    localparam logic [31:0] TAG_KEY = 32'h4D56_304B;
    localparam logic [31:0] TAG_FRM = 32'h4D56_3046;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_ERROR   = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_HDR     = 2'd1,
        KIND_KEY     = 2'd2,
        KIND_FRM     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SIZE_LOW     = 3'd1,
        ST_SHORT_HDR    = 3'd2,
        ST_OVERRUN      = 3'd3,
        ST_SHORT_HDR_CH = 3'd4,
        ST_ZERO_SCALE   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        FLD_NONE    = 3'd0,
        FLD_CODEC   = 3'd1,
        FLD_WIDTH   = 3'd2,
        FLD_HEIGHT  = 3'd3,
        FLD_FRAMES  = 3'd4,
        FLD_LARGEST = 3'd5,
        FLD_RATE    = 3'd6,
        FLD_SCALE   = 3'd7
    } field_t;

    // first payload byte of each header field, last entry ends the scale field
    localparam logic [4:0] FIELD_START [8] = '{
        5'd0, 5'd4, 5'd6, 5'd8, 5'd12, 5'd16, 5'd20, 5'd24
    };

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        chunk_start;
        kind_t       chunk_kind;
        logic [31:0] chunk_total_size;
        logic [47:0] chunk_offset;
        field_t      field_index;
        logic [31:0] field_value;
        status_t     status;
        logic        stream_done;
    } result_t;

    function automatic kind_t kind_of(input logic [31:0] tag);
        kind_t k;
        k = KIND_UNKNOWN;
        priority if (tag == TAG_HDR) k = KIND_HDR;
        else if (tag == TAG_KEY)     k = KIND_KEY;
        else if (tag == TAG_FRM)     k = KIND_FRM;
        else                         k = KIND_UNKNOWN;
        return k;
    endfunction

    // header field slot (0 codec .. 6 scale) that holds a payload byte index
    function automatic logic [2:0] field_slot(input logic [4:0] idx);
        logic [2:0] f;
        f = 3'd0;
        for (int i = 1; i < 7; i++)
        begin
            if (idx >= FIELD_START[i])
            begin
                f = 3'(i);
            end
        end
        return f;
    endfunction

endpackage

/* sv/tcsd_in_reg.sv */
// ----------------------------------------------------------------------------
// tcsd_in_reg
// Input register: holds one stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module tcsd_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_last
);
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign item_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;

endmodule

/* sv/tcsd_core.sv */
// ----------------------------------------------------------------------------
// tcsd_core
// Chunk parser state and the result of one stream byte.
// ----------------------------------------------------------------------------
module tcsd_core #(
    parameter int unsigned OFFSET_BITS = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output tcsd_pkg::result_t result
);
    import tcsd_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             header_count_reg, header_count_next;
    logic [31:0]            tag_shift_reg, tag_shift_next;
    logic [31:0]            size_shift_reg, size_shift_next;
    logic [31:0]            payload_left_reg, payload_left_next;
    logic [OFFSET_BITS-1:0] stream_offset_reg, stream_offset_next;
    logic [OFFSET_BITS-1:0] chunk_base_reg, chunk_base_next;
    logic                   header_seen_reg, header_seen_next;
    logic                   decoding_reg, decoding_next;
    logic [4:0]             field_byte_index_reg, field_byte_index_next;
    logic [31:0]            field_shift_reg, field_shift_next;
    logic                   rate_nonzero_reg, rate_nonzero_next;

    logic [31:0]            size_new;
    logic [31:0]            pay;
    kind_t                  kind;
    logic [OFFSET_BITS-1:0] base_now;
    logic [63:0]            base_wide;
    logic [2:0]             slot;
    logic [1:0]             byte_pos;
    logic [31:0]            field_new;
    field_t                 field_id;

    always_comb
    begin
        phase_next            = phase_reg;
        header_count_next     = header_count_reg;
        tag_shift_next        = tag_shift_reg;
        size_shift_next       = size_shift_reg;
        payload_left_next     = payload_left_reg;
        chunk_base_next       = chunk_base_reg;
        header_seen_next      = header_seen_reg;
        decoding_next         = decoding_reg;
        field_byte_index_next = field_byte_index_reg;
        field_shift_next      = field_shift_reg;
        rate_nonzero_next     = rate_nonzero_reg;
        result                = '0;

        base_now  = (header_count_reg == 3'd0) ? stream_offset_reg : chunk_base_reg;
        base_wide = 64'(base_now);
        size_new  = ((header_count_reg == 3'd0) ? 32'd0 : size_shift_reg)
                  | (header_count_reg[2] ? (32'(data_byte) << {header_count_reg[1:0], 3'b000})
                                         : 32'd0);
        pay       = size_new - 32'(HDR_BYTES);
        kind      = kind_of(tag_shift_reg);
        slot      = field_slot(field_byte_index_reg);
        byte_pos  = 2'(field_byte_index_reg - FIELD_START[slot]);
        field_new = field_shift_reg | (32'(data_byte) << {byte_pos, 3'b000});
        field_id  = field_t'(3'(slot + 3'd1));

        unique case (phase_reg)
            PH_HEADER:
            begin
                chunk_base_next   = base_now;
                size_shift_next   = size_new;
                header_count_next = 3'(header_count_reg + 3'd1);
                if (!header_count_reg[2])
                begin
                    tag_shift_next = {tag_shift_reg[23:0], data_byte};
                end
                if (header_count_reg == 3'd7)
                begin
                    if (size_new < 32'(HDR_BYTES))
                    begin
                        result.status = ST_SIZE_LOW;
                        phase_next    = PH_ERROR;
                    end
                    else if (last_byte && pay != 32'd0)
                    begin
                        result.status = ST_OVERRUN;
                        phase_next    = PH_ERROR;
                    end
                    else
                    begin
                        result.chunk_start      = 1'b1;
                        result.chunk_kind       = kind;
                        result.chunk_total_size = size_new;
                        result.chunk_offset     = base_wide[47:0];
                        if (kind == KIND_HDR && !header_seen_reg)
                        begin
                            header_seen_next = 1'b1;
                            if (pay < 32'(HDR_MIN_PAYLOAD))
                            begin
                                result.status = ST_SHORT_HDR_CH;
                            end
                            else
                            begin
                                decoding_next         = 1'b1;
                                field_byte_index_next = '0;
                                field_shift_next      = '0;
                                rate_nonzero_next     = 1'b0;
                            end
                        end
                        if (pay != 32'd0)
                        begin
                            phase_next        = PH_PAYLOAD;
                            payload_left_next = pay;
                        end
                    end
                end
                else if (last_byte)
                begin
                    result.status = ST_SHORT_HDR;
                end
            end
            PH_PAYLOAD:
            begin
                result.payload_byte  = data_byte;
                result.payload_valid = 1'b1;
                if (decoding_reg && field_byte_index_reg < 5'(HDR_MIN_PAYLOAD))
                begin
                    field_shift_next      = field_new;
                    field_byte_index_next = 5'(field_byte_index_reg + 5'd1);
                    if (5'(field_byte_index_reg + 5'd1) == FIELD_START[3'(slot + 3'd1)])
                    begin
                        result.field_index = field_id;
                        result.field_value = field_new;
                        field_shift_next   = '0;
                        if (field_id == FLD_RATE && field_new != 32'd0)
                        begin
                            rate_nonzero_next = 1'b1;
                        end
                        if (field_id == FLD_SCALE)
                        begin
                            decoding_next = 1'b0;
                            if (field_new == 32'd0 && rate_nonzero_reg)
                            begin
                                result.status = ST_ZERO_SCALE;
                            end
                        end
                    end
                end
                payload_left_next = payload_left_reg - 32'd1;
                if (payload_left_reg == 32'd1)
                begin
                    phase_next    = PH_HEADER;
                    decoding_next = 1'b0;
                end
                else if (last_byte)
                begin
                    result.status = ST_OVERRUN;
                end
            end
            PH_ERROR:
            begin
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        stream_offset_next = (stream_offset_reg != OFFSET_MAX)
                           ? stream_offset_reg + OFFSET_BITS'(1) : stream_offset_reg;

        if (last_byte)
        begin
            result.stream_done    = 1'b1;
            phase_next            = PH_HEADER;
            header_count_next     = '0;
            tag_shift_next        = '0;
            size_shift_next       = '0;
            payload_left_next     = '0;
            stream_offset_next    = '0;
            chunk_base_next       = '0;
            header_seen_next      = 1'b0;
            decoding_next         = 1'b0;
            field_byte_index_next = '0;
            field_shift_next      = '0;
            rate_nonzero_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_HEADER;
            header_count_reg     <= '0;
            tag_shift_reg        <= '0;
            size_shift_reg       <= '0;
            payload_left_reg     <= '0;
            stream_offset_reg    <= '0;
            chunk_base_reg       <= '0;
            header_seen_reg      <= 1'b0;
            decoding_reg         <= 1'b0;
            field_byte_index_reg <= '0;
            field_shift_reg      <= '0;
            rate_nonzero_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg            <= phase_next;
            header_count_reg     <= header_count_next;
            tag_shift_reg        <= tag_shift_next;
            size_shift_reg       <= size_shift_next;
            payload_left_reg     <= payload_left_next;
            stream_offset_reg    <= stream_offset_next;
            chunk_base_reg       <= chunk_base_next;
            header_seen_reg      <= header_seen_next;
            decoding_reg         <= decoding_next;
            field_byte_index_reg <= field_byte_index_next;
            field_shift_reg      <= field_shift_next;
            rate_nonzero_reg     <= rate_nonzero_next;
        end
    end

endmodule

/* sv/tcsd_out_reg.sv */
// ----------------------------------------------------------------------------
// tcsd_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module tcsd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tcsd_pkg::result_t result,
    input  logic              result_ready,
    output logic              result_valid,
    output logic              free,
    output tcsd_pkg::result_t held
);
    import tcsd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free = !valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign result_valid = valid_reg;
    assign held         = data_reg;

endmodule

/* sv/tagged_chunk_stream_deframer.sv */
// ----------------------------------------------------------------------------
// tagged_chunk_stream_deframer
// Tag/length chunk container parser, one stream byte per request.
// ----------------------------------------------------------------------------
// Returns one result for every byte taken; each byte is held in the input
// register, then the parse logic writes its result into the result register.
// A new byte is taken every cycle while results are consumed; the rate is set
// by the single parse step between the two registers. Each chunk start reports
// tag kind, declared size and stream offset; payload bytes pass through, the
// first header chunk, if its payload holds at least 24 bytes, is decoded into
// seven fields, and any structural error silences the stream until its last
// byte, after which the parser starts fresh at offset zero.
module tagged_chunk_stream_deframer #(
    parameter int unsigned OFFSET_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  payload_byte,
    output logic        payload_valid,
    output logic        chunk_start,
    output logic [1:0]  chunk_kind,
    output logic [31:0] chunk_total_size,
    output logic [47:0] chunk_offset,
    output logic [2:0]  field_index,
    output logic [31:0] field_value,
    output logic [2:0]  status,
    output logic        stream_done
);
    import tcsd_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       held_last;
    logic       out_free;
    logic       advance;
    result_t    core_result;
    result_t    out_result;

    assign advance = held_valid && out_free;

    tcsd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .take       (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_last  (held_last)
    );

    tcsd_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (held_byte),
        .last_byte (held_last),
        .result    (core_result)
    );

    tcsd_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .result       (core_result),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .free         (out_free),
        .held         (out_result)
    );

    assign payload_byte     = out_result.payload_byte;
    assign payload_valid    = out_result.payload_valid;
    assign chunk_start      = out_result.chunk_start;
    assign chunk_kind       = out_result.chunk_kind;
    assign chunk_total_size = out_result.chunk_total_size;
    assign chunk_offset     = out_result.chunk_offset;
    assign field_index      = out_result.field_index;
    assign field_value      = out_result.field_value;
    assign status           = out_result.status;
    assign stream_done      = out_result.stream_done;

endmodule

/* sv/tcsd_checker.sv */
// ----------------------------------------------------------------------------
// tcsd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module tcsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [7:0]  payload_byte,
    input logic        payload_valid,
    input logic        chunk_start,
    input logic [31:0] chunk_total_size,
    input logic [2:0]  field_index,
    input logic [2:0]  status
);
    import tcsd_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(payload_byte)
            && $stable(status) && $stable(chunk_start))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && chunk_start |-> status == ST_OK || status == ST_SHORT_HDR_CH)
        else $error("chunk start with error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && chunk_start |-> chunk_total_size >= 32'(HDR_BYTES))
        else $error("chunk start with size below header");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && payload_valid |-> !chunk_start)
        else $error("payload byte marked as chunk start");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && field_index != FLD_NONE |-> payload_valid)
        else $error("header field outside payload");

endmodule

bind tagged_chunk_stream_deframer tcsd_checker u_tcsd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .payload_byte     (payload_byte),
    .payload_valid    (payload_valid),
    .chunk_start      (chunk_start),
    .chunk_total_size (chunk_total_size),
    .field_index      (field_index),
    .status           (status)
);

/* sim/tb_tagged_chunk_stream_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tagged_chunk_stream_deframer
// Self-checking bench for the tag/length chunk container deframer.
// ----------------------------------------------------------------------------
// A short table of hand-written bytes covers the size-below-8, short trailing
// header, short header chunk and payload overrun cases, then random container
// streams follow: mostly well-formed chunk sequences with a decoded header
// chunk, plus truncated streams, undersized chunks and plain noise. Every
// accepted byte runs through a behavioral deframer in the bench, and every
// result is compared field by field in order. Both sides idle at random, the
// receiver holds off for long stretches and the sender drains now and then.
// ----------------------------------------------------------------------------
module tb_tagged_chunk_stream_deframer;

    import tcsd_pkg::*;

    localparam int TOTAL_ITEMS = 1650;
    localparam int DIR_ROWS    = 21;
    localparam int FLD_FIRST [8] = '{0, 4, 6, 8, 12, 16, 20, 24};

    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic        fixed;
        logic        start;
        kind_t       kind;
        logic [31:0] size;
        status_t     st;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        chunk_start;
    logic [1:0]  chunk_kind;
    logic [31:0] chunk_total_size;
    logic [47:0] chunk_offset;
    logic [2:0]  field_index;
    logic [31:0] field_value;
    logic [2:0]  status;
    logic        stream_done;

    // deframer state mirrored in the bench
    phase_t      pr_phase;
    int unsigned pr_hdr_cnt;
    logic [31:0] pr_tag;
    logic [31:0] pr_size;
    logic [31:0] pr_left;
    logic [47:0] pr_offset;
    logic [47:0] pr_base;
    kind_t       pr_kind;
    logic        pr_hdr_seen;
    logic        pr_decoding;
    int unsigned pr_fidx;
    logic [31:0] pr_fshift;
    logic        pr_rate_nz;

    result_t     deframed_q [$];
    logic [7:0]  strm_q [$];
    dir_row_t    dir_rows [DIR_ROWS];

    int  n_sent = 0;
    int  n_streams = 0;
    int  n_checked = 0;
    int  n_starts = 0;
    int  n_fields = 0;
    int  n_errs = 0;
    int  n_fail = 0;
    int  hold_mark = 400;
    bit  flood = 1'b0;
    bit  drain = 1'b0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    tagged_chunk_stream_deframer uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .payload_byte     (payload_byte),
        .payload_valid    (payload_valid),
        .chunk_start      (chunk_start),
        .chunk_kind       (chunk_kind),
        .chunk_total_size (chunk_total_size),
        .chunk_offset     (chunk_offset),
        .field_index      (field_index),
        .field_value      (field_value),
        .status           (status),
        .stream_done      (stream_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic kind_t tag_kind(input logic [31:0] tag);
        kind_t k;
        case (tag)
            TAG_HDR: k = KIND_HDR;
            TAG_KEY: k = KIND_KEY;
            TAG_FRM: k = KIND_FRM;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic void deframe_clear();
        pr_phase    = PH_HEADER;
        pr_hdr_cnt  = 0;
        pr_tag      = '0;
        pr_size     = '0;
        pr_left     = '0;
        pr_offset   = '0;
        pr_base     = '0;
        pr_kind     = KIND_UNKNOWN;
        pr_hdr_seen = 1'b0;
        pr_decoding = 1'b0;
        pr_fidx     = 0;
        pr_fshift   = '0;
        pr_rate_nz  = 1'b0;
    endfunction

    function automatic result_t deframe_step(input logic [7:0] b, input logic fin);
        result_t     r;
        logic [31:0] pay;
        int          f;
        r = '0;
        if (pr_phase == PH_HEADER)
        begin
            if (pr_hdr_cnt == 0)
            begin
                pr_base = pr_offset;
                pr_size = '0;
            end
            if (pr_hdr_cnt < 4)
                pr_tag = {pr_tag[23:0], b};
            else
                pr_size = pr_size | (32'(b) << (8 * (pr_hdr_cnt - 4)));
            pr_hdr_cnt++;
            if (pr_hdr_cnt == HDR_BYTES)
            begin
                pr_hdr_cnt = 0;
                if (pr_size < HDR_BYTES)
                begin
                    r.status = ST_SIZE_LOW;
                    pr_phase = PH_ERROR;
                end
                else
                begin
                    pay = pr_size - HDR_BYTES;
                    if (fin && pay != 0)
                    begin
                        r.status = ST_OVERRUN;
                        pr_phase = PH_ERROR;
                    end
                    else
                    begin
                        pr_kind            = tag_kind(pr_tag);
                        r.chunk_start      = 1'b1;
                        r.chunk_kind       = pr_kind;
                        r.chunk_total_size = pr_size;
                        r.chunk_offset     = pr_base;
                        if (pr_kind == KIND_HDR && !pr_hdr_seen)
                        begin
                            pr_hdr_seen = 1'b1;
                            if (pay < HDR_MIN_PAYLOAD)
                                r.status = ST_SHORT_HDR_CH;
                            else
                            begin
                                pr_decoding = 1'b1;
                                pr_fidx     = 0;
                                pr_fshift   = '0;
                                pr_rate_nz  = 1'b0;
                            end
                        end
                        if (pay != 0)
                        begin
                            pr_phase = PH_PAYLOAD;
                            pr_left  = pay;
                        end
                    end
                end
            end
            else if (fin)
                r.status = ST_SHORT_HDR;
        end
        else if (pr_phase == PH_PAYLOAD)
        begin
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
            if (pr_decoding && pr_fidx < HDR_MIN_PAYLOAD)
            begin
                f = 0;
                while (f < 6 && pr_fidx >= FLD_FIRST[f + 1])
                    f++;
                pr_fshift = pr_fshift | (32'(b) << (8 * ((pr_fidx - FLD_FIRST[f]) & 3)));
                pr_fidx++;
                if (pr_fidx == FLD_FIRST[f + 1])
                begin
                    r.field_index = field_t'(f + 1);
                    r.field_value = pr_fshift;
                    if (f == 5 && pr_fshift != 0)
                        pr_rate_nz = 1'b1;
                    if (f == 6 && pr_fshift == 0 && pr_rate_nz)
                        r.status = ST_ZERO_SCALE;
                    pr_fshift = '0;
                    if (f == 6)
                        pr_decoding = 1'b0;
                end
            end
            pr_left--;
            if (pr_left == 0)
            begin
                pr_phase    = PH_HEADER;
                pr_decoding = 1'b0;
            end
            else if (fin)
                r.status = ST_OVERRUN;
        end
        if (pr_offset != {48{1'b1}})
            pr_offset++;
        if (fin)
        begin
            r.stream_done = 1'b1;
            deframe_clear();
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic sender_gap();
        int g;
        g = (flood || tx_calm) ? 0 : pick_gap();
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] d, input logic fin, input logic fixed,
                             input result_t fixed_res);
        result_t p;
        item_valid <= 1'b1;
        data_byte  <= d;
        last_byte  <= fin;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        p = deframe_step(d, fin);
        if (fixed)
            deframed_q = {deframed_q, fixed_res};
        else
            deframed_q = {deframed_q, p};
        n_sent++;
    endtask

    task automatic cmp_field(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a)
        begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, e, a);
            n_fail++;
        end
    endtask

    task automatic check_result();
        result_t e;
        if (deframed_q.size() == 0)
        begin
            $display("%0t result with nothing expected, payload_byte %0h status %0d",
                     $time, payload_byte, status);
            n_fail++;
            return;
        end
        e = deframed_q.pop_front();
        cmp_field("payload_byte", e.payload_byte, payload_byte);
        cmp_field("payload_valid", e.payload_valid, payload_valid);
        cmp_field("chunk_start", e.chunk_start, chunk_start);
        cmp_field("chunk_kind", e.chunk_kind, chunk_kind);
        cmp_field("chunk_total_size", e.chunk_total_size, chunk_total_size);
        cmp_field("chunk_offset", e.chunk_offset, chunk_offset);
        cmp_field("field_index", e.field_index, field_index);
        cmp_field("field_value", e.field_value, field_value);
        cmp_field("status", e.status, status);
        cmp_field("stream_done", e.stream_done, stream_done);
        n_checked++;
        n_starts += e.chunk_start;
        if (e.field_index != FLD_NONE)
            n_fields++;
        if (e.status != ST_OK)
            n_errs++;
    endtask

    function automatic logic [31:0] pick_tag();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return TAG_KEY;
        else if (r < 8)
            return TAG_FRM;
        else if (r == 8)
            return $urandom;
        return TAG_HDR;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        else if (r < 95)
            return $urandom_range(7, 20);
        return $urandom_range(21, 60);
    endfunction

    task automatic put_chunk(input logic [31:0] tag, input int n_pay);
        logic [31:0] size;
        logic [31:0] rate;
        logic [31:0] scale;
        int          base;
        size = 32'(n_pay) + HDR_BYTES;
        for (int i = 3; i >= 0; i--)
            strm_q = {strm_q, tag[8 * i +: 8]};
        for (int i = 0; i < 4; i++)
            strm_q = {strm_q, size[8 * i +: 8]};
        base = strm_q.size();
        for (int i = 0; i < n_pay; i++)
            strm_q = {strm_q, 8'($urandom)};
        if (n_pay >= HDR_MIN_PAYLOAD)
        begin
            // rate zero or not, scale often zero
            rate  = ($urandom_range(0, 9) < 3) ? 32'd0 : ($urandom | 32'd1);
            scale = ($urandom_range(0, 9) < 4) ? 32'd0 : $urandom;
            for (int i = 0; i < 4; i++)
            begin
                strm_q[base + 16 + i] = rate[8 * i +: 8];
                strm_q[base + 20 + i] = scale[8 * i +: 8];
            end
        end
    endtask

    task automatic build_good_stream();
        int n_chunks;
        if ($urandom_range(0, 9) < 7)
            put_chunk(TAG_HDR, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 23)
                                                          : $urandom_range(24, 36));
        n_chunks = $urandom_range(1, 4);
        for (int k = 0; k < n_chunks; k++)
            put_chunk(pick_tag(), pick_len());
    endtask

    task automatic play_stream(input int cut);
        for (int i = 0; i <= cut; i++)
        begin
            sender_gap();
            send_byte(strm_q[i], i == cut, 1'b0, '0);
        end
        strm_q.delete();
        n_streams++;
    endtask

    // receiver side
    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                check_result();
            if (drain)
                result_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                flood = 1'b0;
                if (n_checked >= hold_mark)
                begin
                    // long hold-off so the block backs up into its input
                    stall_left = 300;
                    flood      = 1'b1;
                    hold_mark += 700;
                    result_ready <= 1'b0;
                end
                else if (!rx_calm && $urandom_range(0, 2) == 0)
                begin
                    stall_left = pick_gap();
                    result_ready <= 1'b0;
                end
                else
                    result_ready <= 1'b1;
                if ($urandom_range(0, 199) == 0)
                    rx_calm = !rx_calm;
            end
        end
    end

    initial
    begin
        dir_row_t row;
        result_t  fixed_res;
        int       kind_sel;
        int       n_noise;
        dir_rows = '{
            // size below 8 on the last byte
            '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h07, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h00, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h00, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h00, 1'b1, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_SIZE_LOW},
            // stream ends inside a chunk header
            '{8'h00, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h00, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h00, 1'b1, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_SHORT_HDR},
            // header chunk too short to decode, then overrun
            '{8'h4D, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h56, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h68, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h64, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h0B, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h00, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h00, 1'b0, 1'b1, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h00, 1'b0, 1'b1, 1'b1, KIND_HDR, 32'd11, ST_SHORT_HDR_CH},
            '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK},
            '{8'h00, 1'b1, 1'b0, 1'b0, KIND_UNKNOWN, 32'd0, ST_OK}
        };
        deframe_clear();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row       = dir_rows[i];
            fixed_res = '0;
            fixed_res.chunk_start      = row.start;
            fixed_res.chunk_kind       = row.kind;
            fixed_res.chunk_total_size = row.size;
            fixed_res.status           = row.st;
            fixed_res.stream_done      = row.fin;
            sender_gap();
            send_byte(row.data, row.fin, row.fixed, fixed_res);
            if (row.fin)
                n_streams++;
        end

        while (n_sent < TOTAL_ITEMS)
        begin
            tx_calm = ($urandom_range(0, 4) == 0);
            if (n_streams % 10 == 5)
            begin
                // let the block run dry before the next stream
                item_valid <= 1'b0;
                @(posedge clk);
                while (deframed_q.size() != 0)
                    @(posedge clk);
            end
            kind_sel = $urandom_range(0, 99);
            if (kind_sel < 65)
            begin
                build_good_stream();
                play_stream(strm_q.size() - 1);
            end
            else if (kind_sel < 80)
            begin
                build_good_stream();
                play_stream($urandom_range(0, strm_q.size() - 1));
            end
            else if (kind_sel < 90)
            begin
                repeat ($urandom_range(0, 2)) put_chunk(pick_tag(), pick_len());
                repeat (4) strm_q = {strm_q, 8'($urandom)};
                strm_q = {strm_q, 8'($urandom_range(0, 7))};
                repeat (3) strm_q = {strm_q, 8'h00};
                repeat ($urandom_range(0, 5)) strm_q = {strm_q, 8'($urandom)};
                play_stream(strm_q.size() - 1);
            end
            else
            begin
                if ($urandom_range(0, 9) < 3)
                    for (int i = 3; i >= 0; i--)
                        strm_q = {strm_q, TAG_FRM[8 * i +: 8]};
                n_noise = $urandom_range(1, 24);
                repeat (n_noise) strm_q = {strm_q, 8'($urandom)};
                play_stream(strm_q.size() - 1);
            end
        end
        item_valid <= 1'b0;
        drain = 1'b1;

        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d bytes in %0d streams, %0d results compared",
                 n_sent, n_streams, n_checked);
        $display("seen %0d chunk starts, %0d decoded header fields, %0d error reports",
                 n_starts, n_fields, n_errs);
        if (n_fail == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", deframed_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
